// File: rtl/core/trimmed_mean_moisture_filter_top_defines.svh
// assertion helpers used by the rtl top
`ifndef TRIMMED_MEAN_MOISTURE_FILTER_TOP_DEFINES_SVH
`define TRIMMED_MEAN_MOISTURE_FILTER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// property check, masked while reset is held
`define TMMF_ASSERT_PROP(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("tmmf property failed");
// plain invariant, masked while reset is held
`define TMMF_ASSERT_HOLDS(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("tmmf invariant failed");
`else
`define TMMF_ASSERT_PROP(lbl, clk, rst_n, prop)
`define TMMF_ASSERT_HOLDS(lbl, clk, rst_n, cond)
`endif

`endif

// File: rtl/core/tmmf_pkg.sv
`default_nettype none

package tmmf_pkg;

    localparam int SAMPLE_BITS  = 12;
    localparam int WINDOW_SIZE  = 15;
    localparam int TRIM_COUNT   = 3;
    localparam int PERCENT_FULL = 100;
    localparam int PCT_W        = 7;

    // keep at least one sample whatever the trim setting
    localparam int TRIM_LIM = (WINDOW_SIZE - 1) / 2;
    localparam int EFF_TRIM = (TRIM_COUNT > TRIM_LIM) ? TRIM_LIM : TRIM_COUNT;
    localparam int KEPT     = WINDOW_SIZE - 2 * EFF_TRIM;

    localparam int COUNT_W = $clog2(WINDOW_SIZE + 1);
    localparam int IDX_W   = $clog2(WINDOW_SIZE);
    localparam int SUM_W   = $clog2(KEPT * (2 ** SAMPLE_BITS - 1) + 1);
    localparam int NUM_W   = $clog2((2 ** SAMPLE_BITS - 1) * PERCENT_FULL + 1);
    localparam int DIV_W0  = (SUM_W > NUM_W) ? SUM_W : NUM_W;
    localparam int DIV_W   = (DIV_W0 > SAMPLE_BITS) ? DIV_W0 : SAMPLE_BITS;
    localparam int DIV_CNT_W = $clog2(DIV_W + 1);
    localparam int DIFF_W  = SAMPLE_BITS + 1;
    localparam int PROD_W  = NUM_W + 1;

    // floor(sum / KEPT) as (sum * ceil(2^shift / KEPT)) >> shift, exact over the sum range
    localparam int     AVG_SHIFT   = SUM_W + $clog2(KEPT);
    localparam longint AVG_RECIP   = ((longint'(1) << AVG_SHIFT) + KEPT - 1) / KEPT;
    localparam int     AVG_RECIP_W = $clog2(AVG_RECIP + 1);
    localparam int     AVG_PROD_W  = SUM_W + AVG_RECIP_W;

    localparam int IN_TDATA_W  = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((PCT_W + SAMPLE_BITS + 7) / 8) * 8;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_DRY = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_WET = CFG_IDX_W'(1);

    localparam logic [SAMPLE_BITS-1:0] DRY_RESET = SAMPLE_BITS'(3200);
    localparam logic [SAMPLE_BITS-1:0] WET_RESET = SAMPLE_BITS'(1200);

    typedef struct packed {
        logic                   valid;
        logic [CFG_IDX_W-1:0]   index;
        logic [SAMPLE_BITS-1:0] data;
    } t_cfg_wr;

    typedef struct packed {
        logic             insert;
        logic             sum_acc;
        logic             sum_first;
        logic [IDX_W-1:0] idx;
        logic             div_start;
        logic             avg_capture;
        logic             mul_load;
        logic             out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic               last_slot;
        logic               div_done;
        logic [COUNT_W-1:0] count;
    } t_dp_status;

endpackage

`default_nettype wire

// File: rtl/core/tmmf_div.sv
`default_nettype none

module tmmf_div (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_start,
    input  wire logic [tmmf_pkg::DIV_W-1:0] i_dividend,
    input  wire logic [tmmf_pkg::DIV_W-1:0] i_divisor,
    output logic                           o_done,
    output logic [tmmf_pkg::DIV_W-1:0]     o_quotient
);

    logic                            r_busy;
    logic                            r_done;
    logic [tmmf_pkg::DIV_CNT_W-1:0]  r_cnt;
    logic [tmmf_pkg::DIV_W-1:0]      r_rem;
    logic [tmmf_pkg::DIV_W-1:0]      r_quo;
    logic [tmmf_pkg::DIV_W-1:0]      r_den;

    logic [tmmf_pkg::DIV_W:0]        w_trial;
    logic                            w_ge;
    logic [tmmf_pkg::DIV_W-1:0]      n_rem;
    logic [tmmf_pkg::DIV_W-1:0]      n_quo;

    // restoring division, one quotient bit per cycle
    always_comb begin
        w_trial = {r_rem, r_quo[tmmf_pkg::DIV_W-1]};
        w_ge    = (w_trial >= {1'b0, r_den});
        n_rem   = w_ge ? tmmf_pkg::DIV_W'(w_trial - {1'b0, r_den})
                       : w_trial[tmmf_pkg::DIV_W-1:0];
        n_quo   = {r_quo[tmmf_pkg::DIV_W-2:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= !i_start && r_busy && (r_cnt == tmmf_pkg::DIV_CNT_W'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= tmmf_pkg::DIV_CNT_W'(tmmf_pkg::DIV_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == tmmf_pkg::DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_den <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

`default_nettype wire

// File: rtl/core/tmmf_dp.sv
`default_nettype none

module tmmf_dp (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire tmmf_pkg::t_cfg_wr               i_cfg,
    input  wire tmmf_pkg::t_dp_cmd               i_cmd,
    input  wire logic [tmmf_pkg::SAMPLE_BITS-1:0] i_sample,
    output tmmf_pkg::t_dp_status                 o_status,
    output logic [tmmf_pkg::PCT_W-1:0]           o_pct,
    output logic [tmmf_pkg::SAMPLE_BITS-1:0]     o_avg,
    output logic                                 o_fault
);

    localparam int SB = tmmf_pkg::SAMPLE_BITS;
    localparam int WS = tmmf_pkg::WINDOW_SIZE;

    logic [SB-1:0]                  r_sorted [WS];
    logic [SB-1:0]                  n_sorted [WS];
    logic [tmmf_pkg::COUNT_W-1:0]   r_count;
    logic [SB-1:0]                  r_dry;
    logic [SB-1:0]                  r_wet;
    logic [tmmf_pkg::SUM_W-1:0]     r_sum;
    logic [SB-1:0]                  r_avg;
    logic signed [tmmf_pkg::PROD_W-1:0] r_prod;
    logic signed [tmmf_pkg::DIFF_W-1:0] r_den;
    logic                           r_fault;
    logic [tmmf_pkg::PCT_W-1:0]     r_out_pct;
    logic [SB-1:0]                  r_out_avg;
    logic                           r_out_fault;

    logic [WS-1:0]                  w_gt;
    logic [tmmf_pkg::AVG_PROD_W-1:0] w_avg_prod;
    logic signed [tmmf_pkg::DIFF_W-1:0] w_diff;
    logic signed [tmmf_pkg::PROD_W-1:0] w_prod;
    logic [tmmf_pkg::PROD_W-1:0]    w_abs_num;
    logic [tmmf_pkg::DIFF_W-1:0]    w_abs_den;
    logic                           w_neg;
    logic [tmmf_pkg::DIV_W-1:0]     w_dividend;
    logic [tmmf_pkg::DIV_W-1:0]     w_divisor;
    logic                           w_div_done;
    logic [tmmf_pkg::DIV_W-1:0]     w_quo;
    logic [tmmf_pkg::PCT_W-1:0]     w_pct;

    // sorted row of cells: each held entry above the new sample moves up one place
    always_comb begin
        for (int i = 0; i < WS; i++) begin
            w_gt[i] = (tmmf_pkg::COUNT_W'(i) < r_count) && (r_sorted[i] > i_sample);
        end
        for (int i = 0; i < WS; i++) begin
            n_sorted[i] = r_sorted[i];
            if (i > 0 && w_gt[(i > 0) ? i - 1 : 0]) begin
                n_sorted[i] = r_sorted[(i > 0) ? i - 1 : 0];
            end else if (w_gt[i] || tmmf_pkg::COUNT_W'(i) == r_count) begin
                n_sorted[i] = i_sample;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.insert) begin
            for (int i = 0; i < WS; i++) begin
                r_sorted[i] <= n_sorted[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_dry   <= tmmf_pkg::DRY_RESET;
            r_wet   <= tmmf_pkg::WET_RESET;
        end else begin
            if (i_cmd.out_load) begin
                r_count <= '0;
            end else if (i_cmd.insert) begin
                r_count <= r_count + 1'b1;
            end
            if (i_cfg.valid) begin
                case (i_cfg.index)
                    tmmf_pkg::CFG_DRY: r_dry <= i_cfg.data;
                    tmmf_pkg::CFG_WET: r_wet <= i_cfg.data;
                    default: ;
                endcase
            end
        end
    end

    // average by reciprocal multiply
    assign w_avg_prod = tmmf_pkg::AVG_PROD_W'(r_sum)
                      * tmmf_pkg::AVG_PROD_W'(tmmf_pkg::AVG_RECIP);

    // map step: signed offset from the dry point scaled to percent
    always_comb begin
        w_diff = $signed({1'b0, r_avg}) - $signed({1'b0, r_dry});
        w_prod = tmmf_pkg::PROD_W'(w_diff)
               * $signed(tmmf_pkg::PROD_W'(tmmf_pkg::PERCENT_FULL));
        w_abs_num = r_prod[tmmf_pkg::PROD_W-1] ? tmmf_pkg::PROD_W'(-r_prod)
                                               : tmmf_pkg::PROD_W'(r_prod);
        w_abs_den = r_den[tmmf_pkg::DIFF_W-1] ? tmmf_pkg::DIFF_W'(-r_den)
                                              : tmmf_pkg::DIFF_W'(r_den);
        w_neg = r_prod[tmmf_pkg::PROD_W-1] ^ r_den[tmmf_pkg::DIFF_W-1];
        w_dividend = tmmf_pkg::DIV_W'(w_abs_num);
        w_divisor  = tmmf_pkg::DIV_W'(w_abs_den);
        // truncation toward zero makes any negative quotient clamp to zero
        if (r_fault || w_neg) begin
            w_pct = '0;
        end else if (w_quo > tmmf_pkg::DIV_W'(tmmf_pkg::PERCENT_FULL)) begin
            w_pct = tmmf_pkg::PCT_W'(tmmf_pkg::PERCENT_FULL);
        end else begin
            w_pct = w_quo[tmmf_pkg::PCT_W-1:0];
        end
    end

    tmmf_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.sum_acc) begin
            if (i_cmd.sum_first) begin
                r_sum <= tmmf_pkg::SUM_W'(r_sorted[i_cmd.idx]);
            end else begin
                r_sum <= r_sum + tmmf_pkg::SUM_W'(r_sorted[i_cmd.idx]);
            end
        end
        if (i_cmd.avg_capture) begin
            r_avg <= SB'(w_avg_prod >> tmmf_pkg::AVG_SHIFT);
        end
        if (i_cmd.mul_load) begin
            r_prod  <= w_prod;
            r_den   <= $signed({1'b0, r_wet}) - $signed({1'b0, r_dry});
            r_fault <= (r_dry == r_wet);
        end
        if (i_cmd.out_load) begin
            r_out_pct   <= w_pct;
            r_out_avg   <= r_avg;
            r_out_fault <= r_fault;
        end
    end

    assign o_status.last_slot = (r_count == tmmf_pkg::COUNT_W'(WS - 1));
    assign o_status.div_done  = w_div_done;
    assign o_status.count     = r_count;
    assign o_pct   = r_out_pct;
    assign o_avg   = r_out_avg;
    assign o_fault = r_out_fault;

endmodule

`default_nettype wire

// File: rtl/core/tmmf_ctrl.sv
`default_nettype none

module tmmf_ctrl (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    input  wire logic                 i_out_ready,
    input  wire tmmf_pkg::t_dp_status i_status,
    output logic                      o_in_ready,
    output logic                      o_out_valid,
    output tmmf_pkg::t_dp_cmd         o_cmd
);

    typedef enum logic [2:0] {
        S_FILL,
        S_SUM,
        S_AVG,
        S_MUL,
        S_PCT_START,
        S_PCT_WAIT,
        S_OUT
    } t_state;

    localparam logic [tmmf_pkg::IDX_W-1:0] IDX_FIRST =
        tmmf_pkg::IDX_W'(tmmf_pkg::EFF_TRIM);
    localparam logic [tmmf_pkg::IDX_W-1:0] IDX_LAST =
        tmmf_pkg::IDX_W'(tmmf_pkg::EFF_TRIM + tmmf_pkg::KEPT - 1);

    t_state                      r_state;
    logic [tmmf_pkg::IDX_W-1:0]  r_idx;
    logic                        r_out_valid;
    logic                        w_accept;
    logic                        w_out_free;

    assign o_in_ready = (r_state == S_FILL);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_out_free = !r_out_valid || i_out_ready;

    always_comb begin
        o_cmd             = '0;
        o_cmd.insert      = w_accept;
        o_cmd.idx         = r_idx;
        o_cmd.sum_acc     = (r_state == S_SUM);
        o_cmd.sum_first   = (r_idx == IDX_FIRST);
        o_cmd.div_start   = (r_state == S_PCT_START);
        o_cmd.avg_capture = (r_state == S_AVG);
        o_cmd.mul_load    = (r_state == S_MUL);
        o_cmd.out_load    = (r_state == S_OUT) && w_out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_FILL;
            r_idx       <= IDX_FIRST;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= ((r_state == S_OUT) && w_out_free)
                        || (r_out_valid && !i_out_ready);
            case (r_state)
                S_FILL: begin
                    if (w_accept && i_status.last_slot) begin
                        r_idx   <= IDX_FIRST;
                        r_state <= S_SUM;
                    end
                end
                S_SUM: begin
                    if (r_idx == IDX_LAST) begin
                        r_state <= S_AVG;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_AVG:       r_state <= S_MUL;
                S_MUL:       r_state <= S_PCT_START;
                S_PCT_START: r_state <= S_PCT_WAIT;
                S_PCT_WAIT: begin
                    if (i_status.div_done) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (w_out_free) begin
                        r_state <= S_FILL;
                    end
                end
                default: r_state <= S_FILL;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

// File: rtl/core/trimmed_mean_moisture_filter_top.sv
// trimmed mean moisture filter
// samples enter on the s_axis channel, one beat per sample, tdata[11:0] the
// raw reading. every 15 samples form a window; it is kept sorted as samples
// arrive, the 3 lowest and 3 highest are dropped and the middle 9 averaged.
// the average is mapped from the dry point (0 %) to the wet point (100 %)
// and clamped to 0..100; one result beat then leaves on m_axis.
// samples 1 to 14 are taken one per cycle with no result. after the 15th
// the block takes no sample while it works the window: it sums the kept
// samples, takes the reciprocal-multiply average, scales it, starts the
// serial percent divider and waits for it, then hands the result to the
// output register.
// the result sits in an output register; while the receiver stalls, the
// next window is still collected and the block waits only at the end of
// that window for the register to free up.
// cfg writes (index 0 dry point, 1 wet point) are always ready; the user
// must make them only while the block is idle, which the block does not
// enforce. reset clears the window count and loads dry 3200 and wet 1200.
`default_nettype none
`include "trimmed_mean_moisture_filter_top_defines.svh"

module trimmed_mean_moisture_filter_top (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_s_axis_tvalid,
    output logic                                        o_s_axis_tready,
    // [11:0] sample
    input  wire logic [tmmf_pkg::IN_TDATA_W-1:0]        i_s_axis_tdata,
    output logic                                        o_m_axis_tvalid,
    input  wire logic                                   i_m_axis_tready,
    // [6:0] moisture_percent, [18:7] trimmed_average
    output logic [tmmf_pkg::OUT_TDATA_W-1:0]            o_m_axis_tdata,
    // [0] calibration_fault
    output logic [0:0]                                  o_m_axis_tuser,
    input  wire logic                                   i_cfg_valid,
    output logic                                        o_cfg_ready,
    input  wire logic [tmmf_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  wire logic [tmmf_pkg::SAMPLE_BITS-1:0]       i_cfg_data
);

    tmmf_pkg::t_cfg_wr                    w_cfg;
    tmmf_pkg::t_dp_cmd                    w_cmd;
    tmmf_pkg::t_dp_status                 w_status;
    logic [tmmf_pkg::PCT_W-1:0]           w_pct;
    logic [tmmf_pkg::SAMPLE_BITS-1:0]     w_avg;
    logic                                 w_fault;

    assign o_cfg_ready = 1'b1;
    assign w_cfg.valid = i_cfg_valid;
    assign w_cfg.index = i_cfg_index;
    assign w_cfg.data  = i_cfg_data;

    tmmf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .i_status    (w_status),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .o_cmd       (w_cmd)
    );

    tmmf_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (w_cfg),
        .i_cmd    (w_cmd),
        .i_sample (i_s_axis_tdata[tmmf_pkg::SAMPLE_BITS-1:0]),
        .o_status (w_status),
        .o_pct    (w_pct),
        .o_avg    (w_avg),
        .o_fault  (w_fault)
    );

    assign o_m_axis_tdata    = tmmf_pkg::OUT_TDATA_W'({w_avg, w_pct});
    assign o_m_axis_tuser[0] = w_fault;

    `TMMF_ASSERT_HOLDS(a_pct_range, i_clk, i_rst_n, !o_m_axis_tvalid || w_pct <= tmmf_pkg::PCT_W'(tmmf_pkg::PERCENT_FULL))
    `TMMF_ASSERT_HOLDS(a_fault_zero, i_clk, i_rst_n, !(o_m_axis_tvalid && w_fault) || w_pct == '0)
    `TMMF_ASSERT_HOLDS(a_count_bound, i_clk, i_rst_n, w_status.count <= tmmf_pkg::COUNT_W'(tmmf_pkg::WINDOW_SIZE))
    `TMMF_ASSERT_PROP(a_no_instant_result, i_clk, i_rst_n, (i_s_axis_tvalid && o_s_axis_tready) |=> !$rose(o_m_axis_tvalid))

endmodule

`default_nettype wire
